@@ rtl/lpf_pkg.sv @@
`timescale 1ns / 1ps
package lpf_pkg;

   // Fixed framing constants
   localparam int unsigned HEADER_LEN     = 5;
   localparam logic [9:0]  ATT_OVERHEAD   = 10'd3;
   localparam logic [9:0]  MIN_MTU        = 10'd23;
   localparam logic [9:0]  BUFFER_BYTES   = 10'd256;
   localparam logic [7:0]  MORE_FLAG_MASK = 8'h80;

   // Register reset values
   localparam logic [9:0]  MTU_RESET      = 10'd23;
   localparam logic [9:0]  ATTR_RESET     = 10'd244;
   localparam logic [7:0]  VERSION_RESET  = 8'h01;

   // CSR map: register index = paddr[3:2]
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0]  REG_MTU     = 2'd0;
   localparam logic [1:0]  REG_ATTR    = 2'd1;
   localparam logic [1:0]  REG_VERSION = 2'd2;

   // Word slots of one item's result group
   localparam int unsigned CHUNK_W = 9;
   localparam logic [2:0]  SLOT_FIRST    = 3'd0;
   localparam logic [2:0]  SLOT_LAST_HDR = 3'd4;
   localparam logic [2:0]  SLOT_DATA     = 3'd5;

   typedef struct packed {
      logic [7:0]         version;
      logic [CHUNK_W-1:0] chunk_lim;   // zero: no room for payload
   } lpf_cfg_type;

   typedef struct packed {
      logic [7:0]  command_id;
      logic [7:0]  message_key;
      logic [15:0] message_length;
      logic [7:0]  data_byte;
      logic        has_data;
   } lpf_item_type;

   typedef struct packed {
      logic               emit;        // at least one word to send
      logic [2:0]         first_slot;
      logic [2:0]         last_slot;
      logic [4:0][7:0]    hdr;
      logic               hdr_end;     // empty fragment ends on last header byte
      logic [7:0]         data;
      logic               data_fe;
      logic               data_me;
      logic               data_se;
      logic [15:0]        sent_next;
      logic [CHUNK_W-1:0] left_next;
   } lpf_frag_type;

endpackage

@@ rtl/lpf_if.sv @@
`timescale 1ns / 1ps
interface lpf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command_id;
   logic [7:0]  message_key;
   logic [15:0] message_length;
   logic [7:0]  data_byte;
   logic        has_data;

   modport source (output valid, command_id, message_key, message_length, data_byte,
                   has_data, input ready);
   modport sink (input valid, command_id, message_key, message_length, data_byte,
                 has_data, output ready);
endinterface

interface lpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       fragment_end;
   logic       message_end;
   logic       size_error;

   modport source (output valid, out_byte, fragment_end, message_end, size_error,
                   input ready);
   modport sink (input valid, out_byte, fragment_end, message_end, size_error,
                 output ready);
endinterface

@@ rtl/lpf_csr.sv @@
`timescale 1ns / 1ps
module lpf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lpf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output lpf_pkg::lpf_cfg_type             cfg
);
   import lpf_pkg::*;

   logic [9:0] mtu_ff, mtu_in;
   logic [9:0] attr_ff, attr_in;
   logic [7:0] version_ff, version_in;
   logic       wr_en;
   logic [1:0] reg_idx;
   logic [9:0] mtu_eff;
   logic [9:0] pkt_a, pkt_b, pkt_c;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   // register writes
   always_comb begin
      mtu_in     = mtu_ff;
      attr_in    = attr_ff;
      version_in = version_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MTU:     mtu_in     = csr_pwdata[9:0];
            REG_ATTR:    attr_in    = csr_pwdata[9:0];
            REG_VERSION: version_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff     <= MTU_RESET;
         attr_ff    <= ATTR_RESET;
         version_ff <= VERSION_RESET;
      end else begin
         mtu_ff     <= mtu_in;
         attr_ff    <= attr_in;
         version_ff <= version_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_MTU:     csr_prdata = {22'd0, mtu_ff};
         REG_ATTR:    csr_prdata = {22'd0, attr_ff};
         REG_VERSION: csr_prdata = {24'd0, version_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   // payload bytes per fragment: clamp MTU, drop overhead, cap at attribute and buffer size, drop header
   always_comb begin
      mtu_eff = (mtu_ff < MIN_MTU) ? MIN_MTU : mtu_ff;
      pkt_a   = (mtu_eff > ATT_OVERHEAD) ? (mtu_eff - ATT_OVERHEAD) : 10'd0;
      pkt_b   = (pkt_a > attr_ff) ? attr_ff : pkt_a;
      pkt_c   = (pkt_b > BUFFER_BYTES) ? BUFFER_BYTES : pkt_b;
      cfg.version = version_ff;
      if (pkt_c > 10'(HEADER_LEN)) begin
         cfg.chunk_lim = CHUNK_W'(pkt_c - 10'(HEADER_LEN));
      end else begin
         cfg.chunk_lim = '0;
      end
   end

endmodule

@@ rtl/lpf_frag.sv @@
`timescale 1ns / 1ps
module lpf_frag (
   input  lpf_pkg::lpf_item_type              item,
   input  lpf_pkg::lpf_cfg_type               cfg,
   input  logic [15:0]                        bytes_sent,
   input  logic [lpf_pkg::CHUNK_W-1:0]        left_in_fragment,
   output lpf_pkg::lpf_frag_type              frag
);
   import lpf_pkg::*;

   logic [15:0]        remain;
   logic               more;
   logic [CHUNK_W-1:0] chunk;
   logic               new_frag;
   logic [CHUNK_W-1:0] left_dec;
   logic               idle_state;

   assign remain     = (item.message_length > bytes_sent) ?
                       (item.message_length - bytes_sent) : 16'd0;
   // more fragments follow exactly when the remainder exceeds one chunk
   assign more       = remain > {{(16-CHUNK_W){1'b0}}, cfg.chunk_lim};
   assign chunk      = more ? cfg.chunk_lim : remain[CHUNK_W-1:0];
   assign new_frag   = (left_in_fragment == '0);
   assign left_dec   = (new_frag ? chunk : left_in_fragment) - CHUNK_W'(1);
   assign idle_state = (bytes_sent == '0) && new_frag;

   always_comb begin
      frag.emit       = 1'b0;
      frag.first_slot = SLOT_DATA;
      frag.last_slot  = SLOT_DATA;
      frag.hdr[0]     = item.command_id;
      frag.hdr[1]     = cfg.version;
      frag.hdr[2]     = item.message_key;
      frag.hdr[3]     = (more ? MORE_FLAG_MASK : 8'h00) | {7'd0, chunk[8]};
      frag.hdr[4]     = chunk[7:0];
      frag.hdr_end    = 1'b0;
      frag.data       = item.data_byte;
      frag.data_fe    = 1'b0;
      frag.data_me    = 1'b0;
      frag.data_se    = 1'b0;
      frag.sent_next  = bytes_sent;
      frag.left_next  = left_in_fragment;

      if (cfg.chunk_lim == '0) begin
         // no room: single error word, message dropped
         frag.emit      = 1'b1;
         frag.data      = 8'h00;
         frag.data_se   = 1'b1;
         frag.sent_next = '0;
         frag.left_next = '0;
      end else if (!item.has_data) begin
         // empty message gives a header-only fragment; ignored mid-message
         if (idle_state) begin
            frag.emit       = 1'b1;
            frag.first_slot = SLOT_FIRST;
            frag.last_slot  = SLOT_LAST_HDR;
            frag.hdr[3]     = 8'h00;
            frag.hdr[4]     = 8'h00;
            frag.hdr_end    = 1'b1;
         end
      end else if (remain == '0) begin
         // surplus byte: drop and clear
         frag.sent_next = '0;
         frag.left_next = '0;
      end else begin
         frag.emit       = 1'b1;
         frag.first_slot = new_frag ? SLOT_FIRST : SLOT_DATA;
         if (remain == 16'd1) begin
            frag.data_fe   = 1'b1;
            frag.data_me   = 1'b1;
            frag.sent_next = '0;
            frag.left_next = '0;
         end else begin
            frag.data_fe   = (left_dec == '0);
            frag.sent_next = bytes_sent + 16'd1;
            frag.left_next = left_dec;
         end
      end
   end

endmodule

@@ rtl/link_payload_fragmenter_top.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Word
// req_chan  in   valid/ready   command_id, message_key, message_length, data_byte, has_data
// rsp_chan  out  valid/ready   out_byte, fragment_end, message_end, size_error
// csr_*     in   APB read/write negotiated_mtu, attribute_max_len, header_version
//
// Each request word yields 0 to 6 response words: one payload byte, plus five header
// bytes where a fragment starts. A request is registered, decoded into a slot group and
// sent one word a cycle from the response register while the response is ready. A byte
// inside a fragment sustains one word per cycle unless the response stalls; the response
// port bounds throughput at one word per cycle. Synchronous reset clears config, state
// and valids. A stalled response holds the group; the input register still takes one.
module link_payload_fragmenter_top (
   input  logic                            clock,
   input  logic                            reset,
   lpf_req_if.sink                         req_chan,
   lpf_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lpf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import lpf_pkg::*;

   lpf_cfg_type        cfg;
   lpf_frag_type       frag;
   lpf_item_type       item_ff;
   logic               in_vld_ff;
   logic [15:0]        sent_ff;
   logic [CHUNK_W-1:0] left_ff;
   logic               res_vld_ff;
   logic [2:0]         idx_ff;
   logic [2:0]         last_ff;
   logic [4:0][7:0]    hdr_ff;
   logic               hdr_end_ff;
   logic [7:0]         data_ff;
   logic               data_fe_ff, data_me_ff, data_se_ff;
   logic               take, res_done, move;

   lpf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lpf_frag u_frag (
      .item             (item_ff),
      .cfg              (cfg),
      .bytes_sent       (sent_ff),
      .left_in_fragment (left_ff),
      .frag             (frag)
   );

   // handshake control
   assign take           = rsp_chan.valid && rsp_chan.ready;
   assign res_done       = take && (idx_ff == last_ff);
   assign move           = in_vld_ff && (!res_vld_ff || res_done);
   assign req_chan.ready = !in_vld_ff || move;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.command_id     <= req_chan.command_id;
         item_ff.message_key    <= req_chan.message_key;
         item_ff.message_length <= req_chan.message_length;
         item_ff.data_byte      <= req_chan.data_byte;
         item_ff.has_data       <= req_chan.has_data;
      end
   end

   // message state advances as a word leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff <= '0;
         left_ff <= '0;
      end else if (move) begin
         sent_ff <= frag.sent_next;
         left_ff <= frag.left_next;
      end
   end

   // response group control
   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
         idx_ff     <= SLOT_FIRST;
         last_ff    <= SLOT_DATA;
      end else if (move) begin
         res_vld_ff <= frag.emit;
         idx_ff     <= frag.first_slot;
         last_ff    <= frag.last_slot;
      end else if (res_done) begin
         res_vld_ff <= 1'b0;
      end else if (take) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

   // response group payload
   always_ff @(posedge clock) begin
      if (move) begin
         hdr_ff     <= frag.hdr;
         hdr_end_ff <= frag.hdr_end;
         data_ff    <= frag.data;
         data_fe_ff <= frag.data_fe;
         data_me_ff <= frag.data_me;
         data_se_ff <= frag.data_se;
      end
   end

   // slot select
   assign rsp_chan.valid = res_vld_ff;
   always_comb begin
      rsp_chan.out_byte     = data_ff;
      rsp_chan.fragment_end = data_fe_ff;
      rsp_chan.message_end  = data_me_ff;
      rsp_chan.size_error   = data_se_ff;
      if (idx_ff < SLOT_DATA) begin
         rsp_chan.out_byte     = hdr_ff[idx_ff];
         rsp_chan.fragment_end = (idx_ff == SLOT_LAST_HDR) && hdr_end_ff;
         rsp_chan.message_end  = (idx_ff == SLOT_LAST_HDR) && hdr_end_ff;
         rsp_chan.size_error   = 1'b0;
      end
   end

endmodule
